/* src/tpsu_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tpsu_pkg
// Shared constants for the transit proof share update block.
// -----------------------------------------------------------------------------
package tpsu_pkg;

   localparam int DATA_WIDTH_DEF = 64;
   localparam int CSR_ADDR_WIDTH = 3;

   // Register indexes of the configuration port
   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_PRIME      = 3'd0,
      CSR_LAGRANGE   = 3'd1,
      CSR_POLY_EVAL  = 3'd2,
      CSR_SECRET     = 3'd3,
      CSR_VERIFY     = 3'd4,
      CSR_PROFILE_EN = 3'd5,
      CSR_VALID_EN   = 3'd6
   } csr_index_type;

   // Operands reduced in the front chain
   localparam int RED_CUM     = 0;
   localparam int RED_RND     = 1;
   localparam int RED_POLY    = 2;
   localparam int RED_SECRET  = 3;
   localparam int RED_VERIFY  = 4;
   localparam int RED_NUM     = 5;

endpackage

/* src/tpsu_mod_add.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tpsu_mod_add
// Modular sum of two residues: (a + b) mod m for a, b below m.
// -----------------------------------------------------------------------------
module tpsu_mod_add #(
   parameter int W = tpsu_pkg::DATA_WIDTH_DEF
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic [W-1:0] m,
   output logic [W-1:0] s
);
   logic [W:0] sum;
   logic [W:0] dif;

   always_comb begin
      sum = {1'b0, a} + {1'b0, b};
      dif = sum - {1'b0, m};
      s   = (sum >= {1'b0, m}) ? dif[W-1:0] : sum[W-1:0];
   end
endmodule

/* src/tpsu_red_cell.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tpsu_red_cell
// One bit step of the reduction chain: acc = (2*acc + src[BIT]) mod m
// for every operand carried along.
// -----------------------------------------------------------------------------
module tpsu_red_cell #(
   parameter int W   = tpsu_pkg::DATA_WIDTH_DEF,
   parameter int NV  = tpsu_pkg::RED_NUM,
   parameter int BIT = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic [W-1:0]           m,
   input  logic                   in_valid,
   input  logic [NV-1:0][W-1:0]   in_src,
   input  logic [NV-1:0][W-1:0]   in_acc,
   input  logic                   in_flag,
   output logic                   out_valid,
   output logic [NV-1:0][W-1:0]   out_src,
   output logic [NV-1:0][W-1:0]   out_acc,
   output logic                   out_flag
);
   logic                 valid_ff;
   logic [NV-1:0][W-1:0] src_ff;
   logic [NV-1:0][W-1:0] acc_ff, acc_in;
   logic                 flag_ff;
   logic [W:0]           dbl [NV];
   logic [W:0]           dif [NV];

   always_comb begin
      for (int v = 0; v < NV; v++) begin
         dbl[v]    = {in_acc[v], in_src[v][BIT]};
         dif[v]    = dbl[v] - {1'b0, m};
         acc_in[v] = (dbl[v] >= {1'b0, m}) ? dif[v][W-1:0] : dbl[v][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         src_ff  <= in_src;
         acc_ff  <= acc_in;
         flag_ff <= in_flag;
      end
   end

   assign out_valid = valid_ff;
   assign out_src   = src_ff;
   assign out_acc   = acc_ff;
   assign out_flag  = flag_ff;
endmodule

/* src/tpsu_mul_cell.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tpsu_mul_cell
// One bit step of the modular multiply: acc = 2*acc (+ share if bit) mod m.
// -----------------------------------------------------------------------------
module tpsu_mul_cell #(
   parameter int W = tpsu_pkg::DATA_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic [W-1:0] m,
   input  logic         coef_bit,
   input  logic         in_valid,
   input  logic [W-1:0] in_share,
   input  logic [W-1:0] in_acc,
   input  logic [W-1:0] in_cum,
   input  logic         in_ok,
   output logic         out_valid,
   output logic [W-1:0] out_share,
   output logic [W-1:0] out_acc,
   output logic [W-1:0] out_cum,
   output logic         out_ok
);
   logic         valid_ff;
   logic [W-1:0] share_ff, acc_ff, cum_ff;
   logic         ok_ff;
   logic [W-1:0] dbl, add, acc_in;

   tpsu_mod_add #(.W(W)) u_dbl (.a(in_acc), .b(in_acc), .m(m), .s(dbl));
   tpsu_mod_add #(.W(W)) u_add (.a(dbl), .b(in_share), .m(m), .s(add));

   assign acc_in = coef_bit ? add : dbl;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         share_ff <= in_share;
         acc_ff   <= acc_in;
         cum_ff   <= in_cum;
         ok_ff    <= in_ok;
      end
   end

   assign out_valid = valid_ff;
   assign out_share = share_ff;
   assign out_acc   = acc_ff;
   assign out_cum   = cum_ff;
   assign out_ok    = ok_ff;
endmodule

/* src/transit_proof_share_update.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// transit_proof_share_update
// Proof-of-transit share update: new cumulative and validator check.
// -----------------------------------------------------------------------------
// Takes one request per clock and returns one response per request, in order.
// A chain of DATA_WIDTH reduction cells brings all operands below the prime,
// two registered stages form the share and the modulo check, a chain of
// DATA_WIDTH multiply cells scans the Lagrange coefficient one bit per cell,
// and an output register holds the response. The pipeline stalls only when
// a response waits and another one reaches the tail. Configure only while no
// request is in flight.
module transit_proof_share_update #(
   parameter int DATA_WIDTH = tpsu_pkg::DATA_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [DATA_WIDTH-1:0] cumulative_in, [2*DATA_WIDTH-1:DATA_WIDTH] packet_random
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [DATA_WIDTH-1:0] cumulative_out, [DATA_WIDTH] proof_ok
   output logic [((DATA_WIDTH+8)/8)*8-1:0]        rsp_tdata,
   input  logic                                   csr_wen,
   input  logic [tpsu_pkg::CSR_ADDR_WIDTH-1:0]    csr_addr,
   input  logic [DATA_WIDTH-1:0]                  csr_wdata
);
   localparam int W  = DATA_WIDTH;
   localparam int NV = tpsu_pkg::RED_NUM;
   localparam int RSP_W = ((DATA_WIDTH+8)/8)*8;

   logic [W-1:0] prime_ff, lagrange_ff, poly_ff, secret_ff, verify_ff;
   logic         profile_ff, validator_ff;

   // configuration; the prime is kept as the effective modulus
   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff     <= W'(2);
         lagrange_ff  <= '0;
         poly_ff      <= '0;
         secret_ff    <= '0;
         verify_ff    <= '0;
         profile_ff   <= 1'b0;
         validator_ff <= 1'b0;
      end else if (csr_wen) begin
         case (tpsu_pkg::csr_index_type'(csr_addr))
            tpsu_pkg::CSR_PRIME:
               prime_ff <= (csr_wdata < W'(2)) ? W'(1) : csr_wdata;
            tpsu_pkg::CSR_LAGRANGE:   lagrange_ff  <= csr_wdata;
            tpsu_pkg::CSR_POLY_EVAL:  poly_ff      <= csr_wdata;
            tpsu_pkg::CSR_SECRET:     secret_ff    <= csr_wdata;
            tpsu_pkg::CSR_VERIFY:     verify_ff    <= csr_wdata;
            tpsu_pkg::CSR_PROFILE_EN: profile_ff   <= csr_wdata[0];
            tpsu_pkg::CSR_VALID_EN:   validator_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic         en;
   logic         tail_valid;
   logic         out_valid_ff;
   logic [W-1:0] out_cum_ff, out_cum_in;
   logic         out_ok_ff;

   // advance unless a response waits and another one reaches the tail
   assign en         = !(tail_valid && out_valid_ff && !rsp_tready);
   assign req_tready = en;

   logic [W-1:0] req_cum, req_rnd, wrap_sum;
   assign req_cum  = req_tdata[W-1:0];
   assign req_rnd  = req_tdata[2*W-1:W];
   assign wrap_sum = req_rnd + verify_ff;

   // reduction chain
   logic                 red_valid [W+1];
   logic [NV-1:0][W-1:0] red_src   [W+1];
   logic [NV-1:0][W-1:0] red_acc   [W+1];
   logic                 red_flag  [W+1];

   always_comb begin
      red_valid[0]                    = req_tvalid;
      red_src[0][tpsu_pkg::RED_CUM]    = req_cum;
      red_src[0][tpsu_pkg::RED_RND]    = req_rnd;
      red_src[0][tpsu_pkg::RED_POLY]   = poly_ff;
      red_src[0][tpsu_pkg::RED_SECRET] = secret_ff;
      red_src[0][tpsu_pkg::RED_VERIFY] = verify_ff;
      red_acc[0]                      = '0;
      red_flag[0]                     = (req_cum == wrap_sum);
   end

   for (genvar k = 0; k < W; k++) begin : g_red
      tpsu_red_cell #(.W(W), .NV(NV), .BIT(W-1-k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .m         (prime_ff),
         .in_valid  (red_valid[k]),
         .in_src    (red_src[k]),
         .in_acc    (red_acc[k]),
         .in_flag   (red_flag[k]),
         .out_valid (red_valid[k+1]),
         .out_src   (red_src[k+1]),
         .out_acc   (red_acc[k+1]),
         .out_flag  (red_flag[k+1])
      );
   end

   // first middle stage: poly + random, random + verify
   logic [W-1:0] pr_sum, rv_sum;
   logic         m1_valid_ff;
   logic [W-1:0] m1_pr_ff, m1_secret_ff, m1_cum_ff;
   logic         m1_ok_ff, m1_ok_in;

   tpsu_mod_add #(.W(W)) u_pr (
      .a(red_acc[W][tpsu_pkg::RED_POLY]), .b(red_acc[W][tpsu_pkg::RED_RND]),
      .m(prime_ff), .s(pr_sum));
   tpsu_mod_add #(.W(W)) u_rv (
      .a(red_acc[W][tpsu_pkg::RED_RND]), .b(red_acc[W][tpsu_pkg::RED_VERIFY]),
      .m(prime_ff), .s(rv_sum));

   assign m1_ok_in = red_flag[W] || (red_src[W][tpsu_pkg::RED_CUM] == rv_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= red_valid[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_pr_ff     <= pr_sum;
         m1_secret_ff <= red_acc[W][tpsu_pkg::RED_SECRET];
         m1_cum_ff    <= red_acc[W][tpsu_pkg::RED_CUM];
         m1_ok_ff     <= m1_ok_in;
      end
   end

   // second middle stage: add the secret share
   logic [W-1:0] share_in;
   logic         m2_valid_ff;
   logic [W-1:0] m2_share_ff, m2_cum_ff;
   logic         m2_ok_ff;

   tpsu_mod_add #(.W(W)) u_ps (
      .a(m1_pr_ff), .b(m1_secret_ff), .m(prime_ff), .s(share_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_share_ff <= share_in;
         m2_cum_ff   <= m1_cum_ff;
         m2_ok_ff    <= m1_ok_ff;
      end
   end

   // multiply chain, coefficient scanned from the top bit
   logic         mul_valid [W+1];
   logic [W-1:0] mul_share [W+1];
   logic [W-1:0] mul_acc   [W+1];
   logic [W-1:0] mul_cum   [W+1];
   logic         mul_ok    [W+1];

   always_comb begin
      mul_valid[0] = m2_valid_ff;
      mul_share[0] = m2_share_ff;
      mul_acc[0]   = '0;
      mul_cum[0]   = m2_cum_ff;
      mul_ok[0]    = m2_ok_ff;
   end

   for (genvar k = 0; k < W; k++) begin : g_mul
      tpsu_mul_cell #(.W(W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .m         (prime_ff),
         .coef_bit  (lagrange_ff[W-1-k]),
         .in_valid  (mul_valid[k]),
         .in_share  (mul_share[k]),
         .in_acc    (mul_acc[k]),
         .in_cum    (mul_cum[k]),
         .in_ok     (mul_ok[k]),
         .out_valid (mul_valid[k+1]),
         .out_share (mul_share[k+1]),
         .out_acc   (mul_acc[k+1]),
         .out_cum   (mul_cum[k+1]),
         .out_ok    (mul_ok[k+1])
      );
   end

   assign tail_valid = mul_valid[W];

   logic [W-1:0] fin_sum;
   tpsu_mod_add #(.W(W)) u_fin (
      .a(mul_cum[W]), .b(mul_acc[W]), .m(prime_ff), .s(fin_sum));

   assign out_cum_in = profile_ff ? fin_sum : '0;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rsp_tready || !out_valid_ff) begin
         out_valid_ff <= tail_valid;
      end
   end

   always_ff @(posedge clock) begin
      if ((rsp_tready || !out_valid_ff) && tail_valid) begin
         out_cum_ff <= out_cum_in;
         out_ok_ff  <= validator_ff && mul_ok[W];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({out_ok_ff, out_cum_ff});

   // checks
   property p_below_prime;
      @(posedge clock) disable iff (reset)
         rsp_tvalid |-> (out_cum_ff < prime_ff);
   endproperty
   a_below_prime: assert property (p_below_prime)
      else $error("response cumulative not below prime");

   property p_profile_off;
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && !profile_ff) |-> (out_cum_ff == '0);
   endproperty
   a_profile_off: assert property (p_profile_off)
      else $error("cumulative nonzero with profile disabled");

   property p_validator_off;
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && !validator_ff) |-> !out_ok_ff;
   endproperty
   a_validator_off: assert property (p_validator_off)
      else $error("proof flag set with validator disabled");

   property p_no_loss;
      @(posedge clock) disable iff (reset)
         (tail_valid && out_valid_ff && !rsp_tready) |-> !req_tready;
   endproperty
   a_no_loss: assert property (p_no_loss)
      else $error("pipeline advanced over a waiting response");

endmodule
